// ===== rtl/core/fwgs_pkg.sv =====
// ============================================================================
// fwgs_pkg - shared types and constants for the full window grid selector
// Register codes, field widths and the decoded configuration record.
// ============================================================================
package fwgs_pkg;

    // Default sizing, handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_WINDOW = 127;

    // Fixed field widths
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int COORD_W    = 12;
    localparam int ROW_W      = 12;
    localparam int HEIGHT_W   = 13;
    localparam int STEP_W     = 8;
    localparam int WIN_W      = 8;   // holds any window up to the largest MAX_WINDOW
    localparam int WIDTH_W    = 15;  // holds any MAX_WIDTH up to 16384

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [STEP_W-1:0]   MAX_STEP   = 8'd255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd3;

    // Reset values of the registers
    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1024;
    localparam logic [7:0]  RST_STEP_SIZE    = 8'd10;
    localparam logic [6:0]  RST_WINDOW_SIZE  = 7'd31;

    // Decoded (clamped) configuration
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [STEP_W-1:0]   step;
        logic [WIN_W-1:0]    win;
    } t_cfg;

    // Scan position information for one pixel, handed to the evaluation stage
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             first_row;
        logic             first_col;
        logic             on_grid;
    } t_scan;

endpackage

// ===== rtl/core/fwgs_cfg_if.sv =====
// ============================================================================
// fwgs_cfg_if - configuration write channel
// Register index and write data with a valid/ready handshake.
// ============================================================================
interface fwgs_cfg_if import fwgs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/fwgs_pix_if.sv =====
// ============================================================================
// fwgs_pix_if - mask pixel stream
// One mask bit per transfer, raster order.
// ============================================================================
interface fwgs_pix_if ();
    logic valid;
    logic ready;
    logic mask_bit;

    modport source (output valid, output mask_bit, input ready);
    modport sink   (input valid, input mask_bit, output ready);
endinterface

// ===== rtl/core/fwgs_ctr_if.sv =====
// ============================================================================
// fwgs_ctr_if - window center stream
// One window center per transfer.
// ============================================================================
interface fwgs_ctr_if import fwgs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;

    modport source (output valid, output center_x, output center_y, input ready);
    modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

// ===== rtl/core/fwgs_cfg_regs.sv =====
// ============================================================================
// fwgs_cfg_regs - configuration registers
// Hold the four registers and present them clamped to their legal ranges.
// ============================================================================
module fwgs_cfg_regs import fwgs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    localparam logic [WIDTH_W-1:0] MaxWidth  = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIN_W-1:0]   MaxWindow = WIN_W'(MAX_WINDOW);

    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [7:0]  r_step;
    logic [6:0]  r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_step   <= RST_STEP_SIZE;
            r_win    <= RST_WINDOW_SIZE;
        end else if (i_wr_en) begin
            case (i_index)
                REG_IMAGE_WIDTH:  r_width  <= i_data;
                REG_IMAGE_HEIGHT: r_height <= i_data;
                REG_STEP_SIZE:    r_step   <= i_data[7:0];
                REG_WINDOW_SIZE:  r_win    <= i_data[6:0];
                default: ;
            endcase
        end
    end

    // Zero means one; oversize values saturate
    always_comb begin
        if (r_width == 13'd0) begin
            o_cfg.width = WIDTH_W'(1);
        end else if (WIDTH_W'(r_width) > MaxWidth) begin
            o_cfg.width = MaxWidth;
        end else begin
            o_cfg.width = WIDTH_W'(r_width);
        end

        if (r_height == 13'd0) begin
            o_cfg.height = HEIGHT_W'(1);
        end else if (r_height > MAX_HEIGHT) begin
            o_cfg.height = MAX_HEIGHT;
        end else begin
            o_cfg.height = r_height;
        end

        o_cfg.step = (r_step == 8'd0) ? STEP_W'(1) : r_step;

        if (r_win == 7'd0) begin
            o_cfg.win = WIN_W'(1);
        end else if (WIN_W'(r_win) > MaxWindow) begin
            o_cfg.win = MaxWindow;
        end else begin
            o_cfg.win = WIN_W'(r_win);
        end
    end

endmodule

// ===== rtl/core/fwgs_scan.sv =====
// ============================================================================
// fwgs_scan - raster position and grid phase counters
// Step column per pixel and row per line; phases move where a window can end.
// ============================================================================
module fwgs_scan import fwgs_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_adv,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output t_scan                        o_scan
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [STEP_W-1:0] r_cph;
    logic [STEP_W-1:0] r_rph;

    logic              col_wrap;
    logic              row_wrap;
    logic              col_live;
    logic              row_live;
    logic [STEP_W-1:0] cph_inc;
    logic [STEP_W-1:0] rph_inc;

    always_comb begin
        col_wrap = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= i_cfg.width;
        row_wrap = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= i_cfg.height;
        col_live = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= WIDTH_W'(i_cfg.win);
        row_live = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= HEIGHT_W'(i_cfg.win);
        cph_inc  = ((9'(r_cph) + 9'd1) >= 9'(i_cfg.step)) ? '0 : r_cph + 8'd1;
        rph_inc  = ((9'(r_rph) + 9'd1) >= 9'(i_cfg.step)) ? '0 : r_rph + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cph <= '0;
            r_rph <= '0;
        end else if (i_adv) begin
            if (col_wrap) begin
                r_col <= '0;
                r_cph <= '0;
                if (row_wrap) begin
                    r_row <= '0;
                    r_rph <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if (row_live) begin
                        r_rph <= rph_inc;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (col_live) begin
                    r_cph <= cph_inc;
                end
            end
        end
    end

    assign o_col            = r_col;
    assign o_scan.row       = r_row;
    assign o_scan.first_row = (r_row == '0);
    assign o_scan.first_col = (r_col == '0);
    assign o_scan.on_grid   = (r_cph == '0) && (r_rph == '0);

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WIDTH_W'(r_col) < WIDTH_W'(MAX_WIDTH))
        else $error("column counter beyond line store depth");

endmodule

// ===== rtl/core/fwgs_line_store.sv =====
// ============================================================================
// fwgs_line_store - per-column vertical run counts
// Synchronous memory with a registered read, a fill count for reset state and
// forwarding of a write that lands on the entry being read.
// ============================================================================
module fwgs_line_store import fwgs_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int DW    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd_hit;
    logic          r_rd_valid;
    // Columns are always written in ascending order from zero, so entries
    // below the fill count are written and all others still read as zero.
    logic [AW:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_fwd_hit  <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en && ({1'b0, i_wr_addr} == r_fill)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_rd_en) begin
                r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_rd_valid <= {1'b0, i_rd_addr} < r_fill;
            end
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(DEPTH))
        else $error("fill count beyond depth");

    a_write_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> ({1'b0, i_wr_addr} <= r_fill))
        else $error("line store write skips an unwritten entry");

endmodule

// ===== rtl/core/full_window_grid_selector.sv =====
// ============================================================================
// full_window_grid_selector - fully covered window finder on a step grid
// Streams a binary mask and reports centers of fully set square windows.
// ============================================================================
// The block takes one mask pixel per clock in raster order and reports, one
// transfer each, the center of every window_size x window_size square that
// is entirely set, lies inside the image and has its top-left corner on the
// step_size grid. A result enters the output register when the pixel that
// completes the window (its bottom-right corner) leaves stage 1. Throughput
// is one pixel per clock: each pixel does one read-modify-write of the column
// line store, read in the accept cycle and written back as it leaves stage
// 1, with the just-written count forwarded when the same column is read again
// at once (one-pixel-wide images). A result register sits on the output; the
// input stalls only while that register holds an untaken result and a pixel
// waits in stage 1 behind it, whether or not that pixel completes a window.
// After reset the line store reads as all zero without a clearing pass; no
// start-up delay. Configuration is written through the register channel,
// which is always ready, and should be changed only while no pixel is in
// flight.
// ============================================================================
module full_window_grid_selector import fwgs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fwgs_cfg_if.sink    i_cfg,
    fwgs_pix_if.sink    i_pix,
    fwgs_ctr_if.source  o_ctr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_WINDOW + 1);
    localparam int XW = ((CW > COORD_W) ? CW : COORD_W) + 1;

    t_cfg          cfg;
    logic [CW-1:0] scan_col;
    t_scan         scan;

    // Stage 1: pixel whose column count is being read
    logic          r_s1_valid;
    logic          r_s1_bit;
    logic [CW-1:0] r_s1_col;
    t_scan         r_s1_scan;

    // Horizontal run of columns whose vertical run is complete
    logic [RW-1:0] r_run;

    // Output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;

    logic          in_xfer;
    logic          s1_adv;
    logic [RW-1:0] mem_count;
    logic [WIN_W-1:0] col_clip;
    logic [WIN_W-1:0] col_next;
    logic [WIN_W-1:0] run_base;
    logic [WIN_W-1:0] run_next;
    logic          hit;
    logic [XW-1:0] cx;
    logic [XW-1:0] cy;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    fwgs_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake: stage 1 drains into the output register when it is free
    // or being emptied in this cycle; a new pixel enters when stage 1
    // is empty or draining.
    // ------------------------------------------------------------------
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_ctr.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_xfer     = i_pix.valid && i_pix.ready;

    // ------------------------------------------------------------------
    // Stage 0: position counters, line store read
    // ------------------------------------------------------------------
    fwgs_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (in_xfer),
        .o_col   (scan_col),
        .o_scan  (scan)
    );

    fwgs_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (RW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (scan_col),
        .o_rd_data (mem_count),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (col_next[RW-1:0])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_bit  <= i_pix.mask_bit;
            r_s1_col  <= scan_col;
            r_s1_scan <= scan;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: update vertical and horizontal runs, test the window
    // ------------------------------------------------------------------
    always_comb begin
        // Clip a count left from a larger window
        col_clip = (WIN_W'(mem_count) > cfg.win) ? cfg.win : WIN_W'(mem_count);
        if (!r_s1_bit) begin
            col_next = '0;
        end else if (r_s1_scan.first_row) begin
            col_next = WIN_W'(1);
        end else if (col_clip < cfg.win) begin
            col_next = col_clip + 1'b1;
        end else begin
            col_next = col_clip;
        end

        // Restart the horizontal run at the left edge
        if (r_s1_scan.first_col) begin
            run_base = '0;
        end else if (WIN_W'(r_run) > cfg.win) begin
            run_base = cfg.win;
        end else begin
            run_base = WIN_W'(r_run);
        end

        if (col_next >= cfg.win) begin
            run_next = (run_base < cfg.win) ? run_base + 1'b1 : run_base;
        end else begin
            run_next = '0;
        end

        hit = (run_next >= cfg.win) && r_s1_scan.on_grid;

        // Center = bottom-right - window + 1 + window / 2
        cx = XW'(r_s1_col) + XW'(1) - XW'(cfg.win) + XW'(cfg.win >> 1);
        cy = XW'(r_s1_scan.row) + XW'(1) - XW'(cfg.win) + XW'(cfg.win >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (s1_adv) begin
            r_run <= run_next[RW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= hit;
        end else if (o_ctr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && hit) begin
            r_out_x <= cx[COORD_W-1:0];
            r_out_y <= cy[COORD_W-1:0];
        end
    end

    assign o_ctr.valid    = r_out_valid;
    assign o_ctr.center_x = r_out_x;
    assign o_ctr.center_y = r_out_y;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (!r_s1_valid || s1_adv))
        else $error("pixel accepted over a stalled stage");

    a_hit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && hit) |=> r_out_valid)
        else $error("window result lost on the way to the output");

endmodule

// ===== bench/window_center_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// window_center_checker - scoreboard for the full window grid selector
// Follows register writes and mask pixel transfers, runs its own scan of the
// mask and compares each center transfer with the oldest predicted center.
// ============================================================================
module window_center_checker import fwgs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fwgs_cfg_if  cfg,
    fwgs_pix_if  pix,
    fwgs_ctr_if  ctr,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_centers
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_center;

    // Registers as written, before clamping
    logic [CFG_DATA_W-1:0] reg_width;
    logic [CFG_DATA_W-1:0] reg_height;
    logic [STEP_W-1:0]     reg_step;
    logic [6:0]            reg_window;

    // Scan state
    logic [6:0]         col_runs [DEF_MAX_WIDTH];
    logic [6:0]         row_run;
    logic [COORD_W-1:0] scan_col;
    logic [ROW_W-1:0]   scan_row;
    logic [STEP_W-1:0]  col_phase;
    logic [STEP_W-1:0]  row_phase;

    t_center centers_due [$];

    function automatic int clip_cfg(input int v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the scan by one pixel; return 1 with the center when a window
    // on the grid is completed by this pixel.
    function automatic bit scan_pixel(input logic b, output t_center pos);
        int w, h, st, win, col, row, cnt, run, tmp;
        bit hit;
        w   = clip_cfg(int'(reg_width), DEF_MAX_WIDTH);
        h   = clip_cfg(int'(reg_height), int'(MAX_HEIGHT));
        st  = clip_cfg(int'(reg_step), int'(MAX_STEP));
        win = clip_cfg(int'(reg_window), DEF_MAX_WINDOW);
        col = int'(scan_col);
        row = int'(scan_row);
        hit = 1'b0;
        pos = '0;

        cnt = int'(col_runs[col]);
        if (cnt > win)
            cnt = win;
        if (!b)
            cnt = 0;
        else if (row == 0)
            cnt = 1;
        else if (cnt < win)
            cnt = cnt + 1;
        col_runs[col] = cnt[6:0];

        run = (col == 0) ? 0 : int'(row_run);
        if (run > win)
            run = win;
        if (cnt >= win) begin
            if (run < win)
                run = run + 1;
        end else begin
            run = 0;
        end
        row_run = run[6:0];

        if (run >= win && col_phase == '0 && row_phase == '0) begin
            hit   = 1'b1;
            tmp   = col + 1 - win + win / 2;
            pos.x = tmp[COORD_W-1:0];
            tmp   = row + 1 - win + win / 2;
            pos.y = tmp[COORD_W-1:0];
        end

        // phases only move once a window can end at this position
        if (col + 1 >= win)
            col_phase = (col_phase + 1 >= st) ? '0 : col_phase + 8'd1;

        if (col + 1 >= w) begin
            scan_col  = '0;
            col_phase = '0;
            if (row + 1 >= win)
                row_phase = (row_phase + 1 >= st) ? '0 : row_phase + 8'd1;
            if (row + 1 >= h) begin
                scan_row  = '0;
                row_phase = '0;
            end else begin
                scan_row = scan_row + 1'b1;
            end
        end else begin
            scan_col = scan_col + 1'b1;
        end
        return hit;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_center due;
        t_center got;
        if (!i_rst_n) begin
            reg_width  = RST_IMAGE_WIDTH;
            reg_height = RST_IMAGE_HEIGHT;
            reg_step   = RST_STEP_SIZE;
            reg_window = RST_WINDOW_SIZE;
            foreach (col_runs[i])
                col_runs[i] = '0;
            row_run   = '0;
            scan_col  = '0;
            scan_row  = '0;
            col_phase = '0;
            row_phase = '0;
            centers_due.delete();
            o_fail_count = 0;
            o_centers    = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_IMAGE_WIDTH:  reg_width  = cfg.data;
                    REG_IMAGE_HEIGHT: reg_height = cfg.data;
                    REG_STEP_SIZE:    reg_step   = cfg.data[STEP_W-1:0];
                    REG_WINDOW_SIZE:  reg_window = cfg.data[6:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                if (scan_pixel(pix.mask_bit, due))
                    centers_due.push_back(due);
            end
            if (ctr.valid && ctr.ready) begin
                got.x = ctr.center_x;
                got.y = ctr.center_y;
                o_centers++;
                if (centers_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: center (%0d, %0d) transferred, expected none",
                                 $time, got.x, got.y);
                end else begin
                    due = centers_due.pop_front();
                    if (got.x !== due.x)
                        report_field("center_x", int'(due.x), int'(got.x));
                    if (got.y !== due.y)
                        report_field("center_y", int'(due.y), int'(got.y));
                end
            end
        end
        o_pending = centers_due.size();
    end

endmodule

// ===== bench/tb_full_window_grid_selector.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_full_window_grid_selector - testbench for the full window grid selector
// Streams directed and random masks under many register settings, with
// bursty pixel input and a stalling center receiver; a separate checker
// predicts every window center and compares the transfers.
// ============================================================================
module tb_full_window_grid_selector;
    import fwgs_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_PIXELS = 850;
    localparam int DRAIN_TAIL    = 6;       // pipeline is two stages deep
    localparam int LONG_HOLD     = 200;     // cycles of receiver hold-off
    localparam int FIRST_HOLD_AT = 300;     // pixel counts that trigger it
    localparam int LAST_HOLD_AT  = 650;
    localparam int CYCLE_LIMIT   = 400_000;

    typedef enum int {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready half the time
        SINK_SPARSE,    // ready a quarter of the time
        SINK_CADENCE    // fixed pattern, low two fifths of the time
    } t_sink_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fwgs_cfg_if cfg_bus ();
    fwgs_pix_if pix_bus ();
    fwgs_ctr_if ctr_bus ();

    int fail_count;
    int pending;
    int centers;

    int pixels_sent   = 0;
    int regs_written  = 0;
    int settings_made = 0;
    int burst_left    = 1;

    always #HALF_PERIOD i_clk = ~i_clk;

    full_window_grid_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_ctr   (ctr_bus)
    );

    window_center_checker center_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg          (cfg_bus),
        .pix          (pix_bus),
        .ctr          (ctr_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_centers    (centers)
    );

    // ------------------------------------------------------------------------
    // Handshake helpers. All of them are entered and left at a rising edge.
    // Ready is sampled at the falling edge, where every signal is settled,
    // and the transfer then happens at the following rising edge.
    // ------------------------------------------------------------------------

    // Write one register; valid stays up so back-to-back writes need no
    // second assignment in the same step. The caller drops it afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic rdy;
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do begin
            @(negedge i_clk);
            rdy = cfg_bus.ready;
            @(posedge i_clk);
        end while (!rdy);
        regs_written++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] w, h, s, win);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_STEP_SIZE, s);
        write_reg(REG_WINDOW_SIZE, win);
        cfg_bus.valid <= 1'b0;
        settings_made++;
    endtask

    // Offer one pixel and hold it until the transfer. At the end of a burst,
    // drop valid for a random gap; otherwise leave it high for the next one.
    task automatic send_pixel(input logic b);
        logic rdy;
        pix_bus.valid    <= 1'b1;
        pix_bus.mask_bit <= b;
        do begin
            @(negedge i_clk);
            rdy = pix_bus.ready;
            @(posedge i_clk);
        end while (!rdy);
        pixels_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // now and then a long burst with no idle cycles at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Send pixels LSB first.
    task automatic send_bits(input logic [15:0] bits, input int count);
        for (int k = 0; k < count; k++)
            send_pixel(bits[k]);
    endtask

    // Stop offering pixels, wait for every predicted center to arrive, then
    // let the last pixels leave the pipeline; they may cause no center.
    task automatic drain();
        pix_bus.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Center receiver: switch at random between stall patterns.
    // Twice, once enough pixels have gone in, hold ready low for a long
    // stretch so the output register fills and the block stalls its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        int         hold_at;
        int         tick;
        logic       next_ready;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_at   = FIRST_HOLD_AT;
        tick      = 0;
        ctr_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left == 0 && hold_at > 0 && pixels_sent >= hold_at) begin
                hold_left = LONG_HOLD;
                hold_at   = (hold_at == FIRST_HOLD_AT) ? LAST_HOLD_AT : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   next_ready = 1'b1;
                    SINK_COIN:   next_ready = 1'($urandom_range(0, 1));
                    SINK_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
                    default:     next_ready = (tick % 5) >= 2;
                endcase
            end
            @(posedge i_clk);
            ctr_bus.ready <= next_ready;
        end
    end

    // Give up on a hung run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d centers still due",
                 $time, cycles, pending);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                    density;
        int                    n;
        int                    random_pixels;
        logic [CFG_DATA_W-1:0] val;

        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_IMAGE_WIDTH;
        cfg_bus.data     <= '0;
        pix_bus.valid    <= 1'b0;
        pix_bus.mask_bit <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (1024 x 1024, step 10, window 31): nothing can fit.
        send_bits(16'b011, 3);
        drain();

        // All-zero registers read as one: every pixel is a frame and a window.
        // The scan column left over from above is past the new width.
        apply_settings('0, '0, '0, '0);
        send_bits(16'b1101, 4);
        drain();

        // Small image, step one, window two; run into the next frame so the
        // column counts restart in row 0.
        apply_settings(13'd3, 13'd2, 13'd1, 13'd2);
        send_bits(16'h1FF, 9);
        drain();

        // Window larger than the image: never a center.
        apply_settings(13'd2, 13'd2, 13'd1, 13'd5);
        send_bits(16'hF, 4);
        drain();

        // All-ones data: width and height saturate, step 255, window 127.
        apply_settings('1, '1, '1, '1);
        send_bits(16'b0111, 4);

        // Random phases: each rewrites a random subset of the registers and
        // then streams a short run of mostly dense mask. Positions, phases
        // and column counts carry over between phases.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            drain();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 19))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = 13'd4096;
                    3:       val = CFG_DATA_W'($urandom_range(21, 8191));
                    default: val = CFG_DATA_W'($urandom_range(1, 20));
                endcase
                write_reg(REG_IMAGE_WIDTH, val);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 19))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = CFG_DATA_W'($urandom_range(13, 8191));
                    default: val = CFG_DATA_W'($urandom_range(1, 12));
                endcase
                write_reg(REG_IMAGE_HEIGHT, val);
            end
            if ($urandom_range(0, 3) != 0) begin
                // upper data bits are junk the register must drop
                val = CFG_DATA_W'($urandom_range(0, 8191));
                case ($urandom_range(0, 19))
                    0:       val[STEP_W-1:0] = '0;
                    1:       val[STEP_W-1:0] = '1;
                    2:       ;
                    default: val[STEP_W-1:0] = STEP_W'($urandom_range(1, 4));
                endcase
                write_reg(REG_STEP_SIZE, val);
            end
            if ($urandom_range(0, 3) != 0) begin
                val = CFG_DATA_W'($urandom_range(0, 8191));
                case ($urandom_range(0, 19))
                    0:       val[6:0] = '0;
                    1:       val[6:0] = '1;
                    2:       ;
                    default: val[6:0] = 7'($urandom_range(1, 5));
                endcase
                write_reg(REG_WINDOW_SIZE, val);
            end
            cfg_bus.valid <= 1'b0;
            settings_made++;

            density = ($urandom_range(0, 3) != 0) ? $urandom_range(880, 1000)
                                                  : $urandom_range(150, 700);
            n = $urandom_range(20, 90);
            repeat (n) send_pixel($urandom_range(0, 999) < density);
            random_pixels += n;
        end
        drain();

        $display("covered %0d mask pixels under %0d register settings (%0d writes)",
                 pixels_sent, settings_made, regs_written);
        $display("compared %0d window centers, with bursty input and long output stalls",
                 centers);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
